/* src/soc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the substring occurrence counter.
package soc_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PATTERN_BYTES   = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 64;
	localparam int LEN_REG_W       = 5;
	localparam int COUNT_W         = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

	typedef logic [PATTERN_BYTES-1:0][7:0] pattern_t;

	typedef struct packed {
		logic               match_ends_here;
		logic [COUNT_W-1:0] occurrences;
		logic               final_result;
	} result_t;

	// pattern byte k, byte 0 first
	function automatic logic [7:0] pattern_at(input pattern_t pat, input logic [3:0] k);
		return pat[k];
	endfunction

endpackage

/* src/substring_occurrence_counter_unit.sv */
`timescale 1ns / 1ps
// Top level of the overlapping substring occurrence counter.
//
// Usage:
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets the
//    pattern length (1..16, larger values act as PATTERN_MAX), 1 pattern bytes
//    0..7, 2 pattern bytes 8..15. cfg_ready is always high; write only while idle.
//  - Input channel (in_valid/in_ready): one text byte per transfer, last_byte
//    marks the end of a text.
//  - Output channel (out_valid/out_ready): exactly one result per input transfer:
//    match flag, saturating running count, and a copy of last_byte.
//  - Throughput: one byte per cycle while in_ready is high. The window is a row of
//    PATTERN_MAX-1 cells that all compare in parallel in the accept cycle.
//  - Results: each is registered in the output register, or in the skid register.
//  - Stall: the output register plus one skid entry absorb one extra transfer;
//    in_ready drops only while the skid entry is occupied.
//  - Reset: pattern length 1, pattern bytes zero, window and count cleared,
//    both result entries empty. A transfer with last_byte set clears the
//    window, byte count and running count after its result is formed.
module substring_occurrence_counter_unit #(
	parameter int PATTERN_MAX = soc_pkg::PATTERN_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [soc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [soc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       text_byte,
	input  logic                             last_byte,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             match_ends_here,
	output logic [soc_pkg::COUNT_W-1:0]      occurrences,
	output logic                             final_result
);
	import soc_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	// configuration registers
	logic [LEN_REG_W-1:0] pattern_length_q;
	pattern_t             pattern_q;

	// per-text state
	logic [LEN_W-1:0]   bytes_seen_q;
	logic [COUNT_W-1:0] match_total_q;

	logic               accept;
	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   seen_next;
	logic [4:0]         last_k;
	logic               head_ok;
	logic [PATTERN_MAX-1:0] cell_ok;
	logic               hit;
	logic [COUNT_W-1:0] total_next;
	result_t            res;
	result_t            res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_REG_W'(1);
			pattern_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_REG_W-1:0];
				REG_PATTERN_LOW:    pattern_q[7:0]   <= cfg_data;
				REG_PATTERN_HIGH:   pattern_q[15:8]  <= cfg_data;
				default:            ;
			endcase
		end
	end

	assign accept = in_valid && in_ready;

	// effective length, clamped to the window size
	assign len = (pattern_length_q > LEN_REG_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
	           : pattern_length_q[LEN_W-1:0];

	// count of bytes in this text, saturating at PATTERN_MAX
	assign seen_next = (bytes_seen_q == LEN_W'(PATTERN_MAX)) ? bytes_seen_q
	                 : bytes_seen_q + LEN_W'(1);

	// newest byte against the pattern's final byte
	assign last_k  = 5'(len) - 5'd1;
	assign head_ok = text_byte == pattern_at(pattern_q, last_k[3:0]);

	// window: cell 0 holds the byte just before the current one
	generate
		if (PATTERN_MAX > 1) begin : g_win
			logic [7:0] cell_byte [PATTERN_MAX-1];
			for (genvar j = 0; j < PATTERN_MAX - 1; j++) begin : g_cell
				soc_cell #(
					.IDX   (j),
					.LEN_W (LEN_W)
				) u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift    (accept),
					.clear    (accept && last_byte),
					.byte_in  ((j == 0) ? text_byte : cell_byte[(j == 0) ? 0 : j - 1]),
					.len      (len),
					.pattern  (pattern_q),
					.byte_out (cell_byte[j]),
					.ok       (cell_ok[j])
				);
			end
		end
	endgenerate
	assign cell_ok[PATTERN_MAX-1] = 1'b1;

	assign hit = (len != '0) && (seen_next >= len) && head_ok && (&cell_ok);

	assign total_next = (hit && match_total_q != COUNT_MAX) ? match_total_q + COUNT_W'(1)
	                  : match_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q  <= '0;
			match_total_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				bytes_seen_q  <= '0;
				match_total_q <= '0;
			end else begin
				bytes_seen_q  <= seen_next;
				match_total_q <= total_next;
			end
		end
	end

	always_comb begin
		res.match_ends_here = hit;
		res.occurrences     = total_next;
		res.final_result    = last_byte;
	end

	soc_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res_out)
	);

	assign match_ends_here = res_out.match_ends_here;
	assign occurrences     = res_out.occurrences;
	assign final_result    = res_out.final_result;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= LEN_W'(PATTERN_MAX)) else $error("byte count past window size");
	a_text_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> bytes_seen_q == '0 && match_total_q == '0)
		else $error("text state not cleared after final byte");
	a_count_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_byte && match_total_q == COUNT_MAX |=> match_total_q == COUNT_MAX)
		else $error("saturated count wrapped");
	a_hit_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hit |=> bytes_seen_q != '0 || $past(last_byte))
		else $error("match reported with no bytes counted");

endmodule

/* src/soc_cell.sv */
`timescale 1ns / 1ps
// One window cell: holds one earlier text byte and checks it against its pattern byte.
module soc_cell #(
	parameter int IDX   = 0,
	parameter int LEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic             clear,
	input  logic [7:0]       byte_in,
	input  logic [LEN_W-1:0] len,
	input  soc_pkg::pattern_t pattern,
	output logic [7:0]       byte_out,
	output logic             ok
);
	import soc_pkg::*;

	logic [7:0] byte_q;
	logic [5:0] len_x;
	logic [5:0] k_x;
	logic       used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	// cell IDX lines up with pattern byte len-2-IDX when it is in use
	always_comb begin
		len_x = 6'(len);
		used  = len_x >= 6'(IDX + 2);
		k_x   = len_x - 6'(IDX + 2);
		ok    = !used || (byte_q == pattern_at(pattern, k_x[3:0]));
	end

	assign byte_out = byte_q;

endmodule

/* src/soc_skid.sv */
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register.
module soc_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  soc_pkg::result_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output soc_pkg::result_t out_data
);
	import soc_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    take;
	logic    drain;

	assign in_ready = !skid_valid_q;
	assign take     = in_valid && in_ready;
	assign drain    = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= in_data;
			end
		end else if (take) begin
			skid_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q) else $error("skid entry without output entry");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready && take |=> skid_valid_q && !in_ready)
		else $error("transfer into full output not held in skid");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the overlapping substring occurrence counter.
module tb;

	import soc_pkg::*;

	// index the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int STALL_MAX      = 13;     // longest per-transfer gap on either side
	localparam int HOLD_CYCLES    = 300;    // long output hold-off for the pressure test
	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on any channel
	localparam int RANDOM_ITEMS   = 1100;
	localparam int PHASE_ITEMS    = 120;    // minimum text bytes per random pattern setting
	localparam int LONG_TEXT_LEN  = 160;    // one text where every byte matches

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            text_byte;
	logic                  last_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic                  match_ends_here;
	logic [COUNT_W-1:0]    occurrences;
	logic                  final_result;

	// Pattern registers as the block should hold them.
	logic [LEN_REG_W-1:0]  cur_len;
	pattern_t              cur_pattern;

	// Per-text state: earlier bytes (entry 0 newest), bytes seen, running count.
	logic [7:0]            window_q [0:PATTERN_MAX_DEF-2];
	int                    window_fill;
	logic [COUNT_W-1:0]    text_count;

	result_t               results_due [$];
	int                    error_count;
	int                    idle_cycles = 0;

	// Idling controls shared by the sender, the result sink and the tests.
	bit                    send_idle;
	bit                    recv_idle;
	int                    hold_request;

	substring_occurrence_counter_unit #(.PATTERN_MAX(PATTERN_MAX_DEF)) u_top (.*);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Match prediction
	// ------------------------------------------------------------------

	function automatic void clear_text_state();
		foreach (window_q[k]) window_q[k] = 8'h00;
		window_fill = 0;
		text_count  = '0;
	endfunction

	// Works out the result for one text byte and advances the text state.
	function automatic result_t predict_match(input logic [7:0] b, input logic last);
		int      span;
		int      fill;
		logic    hit;
		result_t r;
		// lengths above the maximum act as the maximum; zero never matches
		span = (cur_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(cur_len);
		fill = (window_fill + 1 > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : window_fill + 1;
		hit  = 1'b0;
		// a match needs at least span bytes of this text, so zeros left in the
		// window after a clear can never complete a pattern
		if (span >= 1 && fill >= span) begin
			hit = (b == cur_pattern[span-1]);
			for (int j = 1; j < span; j++) begin
				if (window_q[j-1] != cur_pattern[span-1-j]) hit = 1'b0;
			end
		end
		if (hit && text_count != COUNT_MAX) text_count = text_count + 1'b1;
		r.match_ends_here = hit;
		r.occurrences     = text_count;
		r.final_result    = last;
		if (last) begin
			clear_text_state();
		end else begin
			for (int k = PATTERN_MAX_DEF - 2; k > 0; k--) window_q[k] = window_q[k-1];
			window_q[0] = b;
			window_fill = fill;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking: every output transfer against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: match_ends_here %0d occurrences %0d final_result %0d",
					match_ends_here, occurrences, final_result);
				error_count++;
			end else begin
				want = results_due.pop_front();
				if (match_ends_here !== want.match_ends_here) begin
					$error("match_ends_here: expected %0d, actual %0d",
						want.match_ends_here, match_ends_here);
					error_count++;
				end
				if (occurrences !== want.occurrences) begin
					$error("occurrences: expected %0d, actual %0d", want.occurrences, occurrences);
					error_count++;
				end
				if (final_result !== want.final_result) begin
					$error("final_result: expected %0d, actual %0d",
						want.final_result, final_result);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a run that stops moving on every channel is a failure.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Result sink: per transfer, a random hold-off when recv_idle is set (or a
	// requested long one), then ready stays high until the transfer happens.
	// ------------------------------------------------------------------

	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_request > 0) begin
				stall        = hold_request;
				hold_request = 0;
			end else begin
				stall = recv_idle ? $urandom_range(0, STALL_MAX) : 0;
			end
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Channel tasks; all start and end on a falling edge
	// ------------------------------------------------------------------

	// One text byte transfer; the prediction is queued at the accepting edge.
	task automatic send_char(input logic [7:0] b, input logic last);
		int gap;
		gap = send_idle ? $urandom_range(0, STALL_MAX) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		text_byte = b;
		last_byte = last;
		do @(posedge clk); while (in_ready !== 1'b1);
		results_due.push_back(predict_match(b, last));
		@(negedge clk);
	endtask

	// Stop offering text and let every due result arrive. Each byte gives a
	// result, so the block is idle once the queue is empty.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Register write transfer; leaves cfg_valid high for a following write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_PATTERN_LENGTH: cur_len          = d[LEN_REG_W-1:0];
			REG_PATTERN_LOW:    cur_pattern[7:0]  = d;
			REG_PATTERN_HIGH:   cur_pattern[15:8] = d;
			default: ;  // unknown index: no effect
		endcase
		@(negedge clk);
	endtask

	task automatic set_pattern(input logic [LEN_REG_W-1:0] len, input logic [63:0] lo,
			input logic [63:0] hi);
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
		write_reg(REG_PATTERN_LOW, lo);
		write_reg(REG_PATTERN_HIGH, hi);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: length 1, pattern byte zero. A zero text byte is an
	// ordinary character and matches.
	task automatic test_reset_defaults();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		wait_idle();
	endtask

	// Zero length never matches; a pattern longer than the text cannot match
	// even when the cleared window holds the leading pattern bytes (zeros).
	task automatic test_short_texts();
		write_reg(REG_UNUSED, '1);
		set_pattern(5'd0, 64'h0, 64'h0);
		send_char(8'h00, 1'b0);
		send_char(8'h00, 1'b1);
		wait_idle();
		set_pattern(5'd4, 64'h44_00_00_00, 64'h0);
		send_char(8'h44, 1'b1);
		wait_idle();
	endtask

	// Overlapping occurrences all count.
	task automatic test_overlap();
		set_pattern(5'd2, 64'h61_61, 64'h0);
		send_char(8'h61, 1'b0);
		send_char(8'h61, 1'b0);
		send_char(8'h61, 1'b1);
		wait_idle();
	endtask

	// Largest length field acts as the full 16-byte pattern.
	task automatic test_longest_pattern();
		set_pattern('1, '1, '1);
		for (int i = 0; i < PATTERN_MAX_DEF; i++) send_char(8'hFF, i == PATTERN_MAX_DEF - 1);
		wait_idle();
	endtask

	// Every byte matches; the count climbs by one per byte through a long text.
	task automatic test_long_text();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		set_pattern(5'd1, 64'h5A, 64'h0);
		for (int i = 0; i < LONG_TEXT_LEN; i++) send_char(8'h5A, i == LONG_TEXT_LEN - 1);
		wait_idle();
	endtask

	// Sink holds off for a long stretch while text keeps coming, so the
	// result buffer fills and in_ready drops.
	task automatic test_backpressure();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		set_pattern(5'd3, 64'h61_62_61, 64'h0);
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 48; i++) begin
			send_char($urandom_range(0, 1) ? 8'h61 : 8'h62, (i % 12) == 11);
		end
		wait_idle();
	endtask

	// Random pattern settings; texts are mostly built from pattern copies and
	// pattern bytes so matches and overlaps are frequent, with some noise.
	task automatic test_random();
		int           items_done;
		int           phase_done;
		int           span;
		int           target;
		int           r;
		logic [LEN_REG_W-1:0] len;
		pattern_t     pat;
		logic [7:0]   a;
		logic [7:0]   c;
		logic [7:0]   text [$];
		items_done = 0;
		while (items_done < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			case (r)
				0:       len = 5'd0;
				1:       len = 5'd16;
				2:       len = LEN_REG_W'($urandom_range(17, 31));
				default: len = LEN_REG_W'($urandom_range(1, 6));
			endcase
			if ($urandom_range(0, 2) != 0) begin
				// two-letter alphabet makes self-overlapping patterns likely
				a = 8'($urandom_range(0, 255));
				c = 8'($urandom_range(0, 255));
				for (int k = 0; k < PATTERN_BYTES; k++) pat[k] = $urandom_range(0, 1) ? a : c;
			end else begin
				pat = {$urandom, $urandom, $urandom, $urandom};
			end
			if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
			set_pattern(len, pat[7:0], pat[15:8]);
			span = (len == 0) ? 4 : ((len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len));
			phase_done = 0;
			while (phase_done < PHASE_ITEMS) begin
				// about one text in four runs without gaps on a side
				send_idle = $urandom_range(0, 3) != 0;
				recv_idle = $urandom_range(0, 3) != 0;
				target = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
					: $urandom_range(4, 40);
				text.delete();
				while (text.size() < target) begin
					r = $urandom_range(0, 9);
					if (r < 4) begin
						for (int k = 0; k < span; k++) text.push_back(pat[k]);
					end else if (r < 8) begin
						text.push_back(pat[$urandom_range(0, span - 1)]);
					end else begin
						text.push_back(8'($urandom_range(0, 255)));
					end
				end
				foreach (text[i]) send_char(text[i], i == text.size() - 1);
				phase_done += text.size();
			end
			items_done += phase_done;
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_PATTERN_LENGTH;
		cfg_data     = '0;
		in_valid     = 1'b0;
		text_byte    = 8'h00;
		last_byte    = 1'b0;
		send_idle    = 1'b0;
		recv_idle    = 1'b0;
		hold_request = 0;
		error_count  = 0;
		cur_len      = LEN_REG_W'(1);
		cur_pattern  = '0;
		clear_text_state();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_short_texts();
		test_overlap();
		test_longest_pattern();
		test_long_text();
		test_backpressure();
		test_random();

		// all results in; allow the latency once more before the verdict
		wait_idle();
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/soc_pkg.sv
src/soc_cell.sv
src/soc_skid.sv
src/substring_occurrence_counter_unit.sv
sim/tb.sv
